// File: rtl/core/sct_pkg.sv
package sct_pkg;

  localparam int KEY_W = 64;

  typedef enum logic [1:0] {
    KIND_LOOKUP  = 2'd0,
    KIND_ADD_ORD = 2'd1,
    KIND_ADD_TL  = 2'd2,
    KIND_SORT    = 2'd3
  } kind_t;

  typedef enum logic {
    REG_MISSING = 1'b0,
    REG_SORT_EN = 1'b1
  } reg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISPATCH,
    ST_BS_CHK, ST_BS_CMP, ST_BS_CR, ST_BS_CL, ST_BS_FAIL,
    ST_MS_INIT, ST_MS_CHK, ST_MS_CMP,
    ST_SA_CHK, ST_SA_CMP, ST_SH_CHK, ST_SH_WR,
    ST_TA_CHK, ST_TA_CMP,
    ST_SO_INIT, ST_SO_CHK, ST_SO_LDV, ST_SO_IN, ST_SO_CMP,
    ST_FIN
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD,
    OP_BS_STEP, OP_BS_CMP, OP_RD_R, OP_RD_L,
    OP_HIT_MID, OP_HIT_R, OP_HIT_L, OP_HIT_I, OP_HIT_MISS,
    OP_MISS_INIT, OP_RD_I, OP_INC_I,
    OP_RES_ZERO, OP_RES_FULL,
    OP_RD_JM1, OP_WR_J, OP_WR_X_I, OP_WR_X_N,
    OP_SORT_INIT, OP_LOAD_V, OP_WR_V,
    OP_EMIT
  } op_t;

  typedef struct packed {
    kind_t kind;
    logic  bs_empty;
    logic  bs_more;
    logic  lt;
    logic  eq;
    logic  miss_done;
    logic  i_neg;
    logic  i_eq_n;
    logic  full;
    logic  j_eq_i;
    logic  j_zero;
    logic  gt_v;
    logic  sort_go;
    logic  i_gt_last;
    logic  out_free;
  } status_t;

endpackage

// File: rtl/core/sct_datapath.sv
module sct_datapath #(
  parameter int TABLE_DEPTH = 256,
  parameter int CODE_BYTES  = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  sct_pkg::op_t           op,
  output sct_pkg::status_t       status,
  input  logic [1:0]             kind_in,
  input  logic [63:0]            code_in,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [1:0]             cfg_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             out_position,
  output logic                   out_found,
  output logic                   out_missing,
  output logic                   out_full,
  output logic [8:0]             out_entries
);
  import sct_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam logic [63:0] KEY_MASK = ~64'd0 << (8 * (8 - CODE_BYTES));

  logic [KEY_W-1:0] mem [TABLE_DEPTH];
  logic [KEY_W-1:0] rdata, x, v;
  logic [AW-1:0]    ra, wa;
  logic [KEY_W-1:0] wd;
  logic             we;

  kind_t                kind;
  logic [1:0]           miss_cnt;
  logic                 sort_en;
  logic [CW-1:0]        count;
  logic signed [SW-1:0] l, r, mid_q, i;
  logic [CW-1:0]        j;
  logic [1:0]           mj;

  logic [AW-1:0] pos;
  logic          fnd, mis, ful;

  logic [1:0]           nm;
  logic signed [SW-1:0] cnt_s, nm_s, last, mid;
  logic [SW:0]          msum;
  logic signed [SW:0]   diff;

  assign nm    = (miss_cnt == 2'd3) ? 2'd2 : miss_cnt;
  assign cnt_s = $signed({1'b0, count});
  assign nm_s  = $signed({{(SW-2){1'b0}}, nm});
  assign last  = cnt_s - SW'(1) - nm_s;
  assign msum  = {1'b0, l} + {1'b0, r};
  assign mid   = $signed(msum[SW:1]);
  assign diff  = $signed({r[SW-1], r}) - $signed({l[SW-1], l});

  // memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata <= mem[ra];
  end

  always_comb begin
    ra = i[AW-1:0];
    case (op)
      OP_BS_STEP: ra = mid[AW-1:0];
      OP_RD_R:    ra = r[AW-1:0];
      OP_RD_L:    ra = l[AW-1:0];
      OP_RD_JM1:  ra = AW'(j - CW'(1));
      default:    ra = i[AW-1:0];
    endcase
  end

  always_comb begin
    we = 1'b0;
    wa = j[AW-1:0];
    wd = rdata;
    case (op)
      OP_WR_J:   we = 1'b1;
      OP_WR_V:   begin we = 1'b1; wd = v; end
      OP_WR_X_I: begin we = 1'b1; wa = i[AW-1:0]; wd = x; end
      OP_WR_X_N: begin we = 1'b1; wa = count[AW-1:0]; wd = x; end
      default:   we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      miss_cnt <= 2'd0;
      sort_en  <= 1'b1;
    end else if (cfg_we) begin
      if (cfg_index == REG_MISSING) begin
        miss_cnt <= cfg_data;
      end else begin
        sort_en <= cfg_data[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (op == OP_WR_X_I || op == OP_WR_X_N) begin
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        kind <= kind_t'(kind_in);
        x    <= code_in & KEY_MASK;
        l    <= '0;
        r    <= (kind_t'(kind_in) == KIND_LOOKUP) ? last : cnt_s - SW'(1);
        i    <= '0;
        j    <= count;
      end
      OP_BS_STEP: mid_q <= mid;
      OP_BS_CMP: begin
        if (x < rdata) begin
          r <= mid_q;
        end else begin
          l <= mid_q;
        end
      end
      OP_HIT_MID:  begin pos <= mid_q[AW-1:0]; fnd <= 1'b1; mis <= 1'b0; ful <= 1'b0; end
      OP_HIT_R:    begin pos <= r[AW-1:0]; fnd <= 1'b1; mis <= 1'b0; ful <= 1'b0; end
      OP_HIT_L:    begin pos <= l[AW-1:0]; fnd <= 1'b1; mis <= 1'b0; ful <= 1'b0; end
      OP_HIT_I:    begin pos <= i[AW-1:0]; fnd <= 1'b1; mis <= 1'b0; ful <= 1'b0; end
      OP_HIT_MISS: begin pos <= i[AW-1:0]; fnd <= 1'b1; mis <= 1'b1; ful <= 1'b0; end
      OP_RES_ZERO: begin pos <= '0; fnd <= 1'b0; mis <= 1'b0; ful <= 1'b0; end
      OP_RES_FULL: begin pos <= '0; fnd <= 1'b0; mis <= 1'b0; ful <= 1'b1; end
      OP_MISS_INIT: begin
        i  <= cnt_s - nm_s;
        mj <= 2'd0;
      end
      OP_INC_I: begin
        i  <= i + SW'(1);
        mj <= mj + 2'd1;
      end
      OP_WR_J: j <= j - CW'(1);
      OP_WR_X_I: begin pos <= i[AW-1:0]; fnd <= 1'b0; mis <= 1'b0; ful <= 1'b0; end
      OP_WR_X_N: begin pos <= count[AW-1:0]; fnd <= 1'b0; mis <= 1'b0; ful <= 1'b0; end
      OP_SORT_INIT: i <= SW'(1);
      OP_LOAD_V: begin
        v <= rdata;
        j <= i[CW-1:0];
      end
      OP_WR_V: i <= i + SW'(1);
      default: ;
    endcase
  end

  // result register, freed by the downstream handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op == OP_EMIT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_EMIT) begin
      out_position <= 8'(pos);
      out_found    <= fnd;
      out_missing  <= mis;
      out_full     <= ful;
      out_entries  <= 9'(count);
    end
  end

  always_comb begin
    status.kind      = kind;
    status.bs_empty  = r < 0;
    status.bs_more   = diff > 1;
    status.lt        = x < rdata;
    status.eq        = x == rdata;
    status.miss_done = mj == nm;
    status.i_neg     = i < 0;
    status.i_eq_n    = i == cnt_s;
    status.full      = count == CW'(TABLE_DEPTH);
    status.j_eq_i    = $signed({1'b0, j}) == i;
    status.j_zero    = j == '0;
    status.gt_v      = rdata > v;
    status.sort_go   = sort_en && (last > 0);
    status.i_gt_last = i > last;
    status.out_free  = !out_valid || out_ready;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    we |-> ({1'b0, wa} <= count))
    else $error("write beyond filled region");

  a_add_grows: assert property (@(posedge clk) disable iff (rst)
    (op == OP_WR_X_I || op == OP_WR_X_N) |=> count == $past(count) + CW'(1))
    else $error("add did not grow the table");

endmodule

// File: rtl/core/sct_ctrl.sv
module sct_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  sct_pkg::status_t status,
  output sct_pkg::op_t     op
);
  import sct_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = state == ST_IDLE;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (in_valid) state_next = ST_DISPATCH;
      ST_DISPATCH: begin
        case (status.kind)
          KIND_LOOKUP, KIND_ADD_ORD: state_next = ST_BS_CHK;
          KIND_ADD_TL:               state_next = ST_TA_CHK;
          default:                   state_next = ST_SO_INIT;
        endcase
      end
      ST_BS_CHK: begin
        if (status.bs_empty)     state_next = ST_BS_FAIL;
        else if (status.bs_more) state_next = ST_BS_CMP;
        else                     state_next = ST_BS_CR;
      end
      ST_BS_CMP:  state_next = status.eq ? ST_FIN : ST_BS_CHK;
      ST_BS_CR:   state_next = status.eq ? ST_FIN : ST_BS_CL;
      ST_BS_CL:   state_next = status.eq ? ST_FIN : ST_BS_FAIL;
      ST_BS_FAIL: begin
        if (status.kind == KIND_LOOKUP) state_next = ST_MS_INIT;
        else if (status.full)           state_next = ST_FIN;
        else                            state_next = ST_SA_CHK;
      end
      ST_MS_INIT: state_next = ST_MS_CHK;
      ST_MS_CHK: begin
        if (status.miss_done)   state_next = ST_FIN;
        else if (!status.i_neg) state_next = ST_MS_CMP;
      end
      ST_MS_CMP:  state_next = status.eq ? ST_FIN : ST_MS_CHK;
      ST_SA_CHK:  state_next = status.i_eq_n ? ST_SH_CHK : ST_SA_CMP;
      ST_SA_CMP:  state_next = status.lt ? ST_SH_CHK : ST_SA_CHK;
      ST_SH_CHK:  state_next = status.j_eq_i ? ST_FIN : ST_SH_WR;
      ST_SH_WR:   state_next = ST_SH_CHK;
      ST_TA_CHK:  state_next = status.i_eq_n ? ST_FIN : ST_TA_CMP;
      ST_TA_CMP:  state_next = status.eq ? ST_FIN : ST_TA_CHK;
      ST_SO_INIT: state_next = status.sort_go ? ST_SO_CHK : ST_FIN;
      ST_SO_CHK:  state_next = status.i_gt_last ? ST_FIN : ST_SO_LDV;
      ST_SO_LDV:  state_next = ST_SO_IN;
      ST_SO_IN:   state_next = status.j_zero ? ST_SO_CHK : ST_SO_CMP;
      ST_SO_CMP:  state_next = status.gt_v ? ST_SO_IN : ST_SO_CHK;
      ST_FIN:     if (status.out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    op = OP_NONE;
    case (state)
      ST_IDLE: if (in_valid) op = OP_LOAD;
      ST_BS_CHK: begin
        if (status.bs_empty)     op = OP_NONE;
        else if (status.bs_more) op = OP_BS_STEP;
        else                     op = OP_RD_R;
      end
      ST_BS_CMP:  op = status.eq ? OP_HIT_MID : OP_BS_CMP;
      ST_BS_CR:   op = status.eq ? OP_HIT_R : OP_RD_L;
      ST_BS_CL:   op = status.eq ? OP_HIT_L : OP_NONE;
      ST_BS_FAIL: begin
        if (status.kind != KIND_LOOKUP && status.full) op = OP_RES_FULL;
      end
      ST_MS_INIT: op = OP_MISS_INIT;
      ST_MS_CHK: begin
        if (status.miss_done)  op = OP_RES_ZERO;
        else if (status.i_neg) op = OP_INC_I;
        else                   op = OP_RD_I;
      end
      ST_MS_CMP:  op = status.eq ? OP_HIT_MISS : OP_INC_I;
      ST_SA_CHK:  op = status.i_eq_n ? OP_NONE : OP_RD_I;
      ST_SA_CMP:  op = status.lt ? OP_NONE : OP_INC_I;
      ST_SH_CHK:  op = status.j_eq_i ? OP_WR_X_I : OP_RD_JM1;
      ST_SH_WR:   op = OP_WR_J;
      ST_TA_CHK: begin
        if (!status.i_eq_n)  op = OP_RD_I;
        else if (status.full) op = OP_RES_FULL;
        else                 op = OP_WR_X_N;
      end
      ST_TA_CMP:  op = status.eq ? OP_HIT_I : OP_INC_I;
      ST_SO_INIT: op = status.sort_go ? OP_SORT_INIT : OP_RES_ZERO;
      ST_SO_CHK:  op = status.i_gt_last ? OP_RES_ZERO : OP_RD_I;
      ST_SO_LDV:  op = OP_LOAD_V;
      ST_SO_IN:   op = status.j_zero ? OP_WR_V : OP_RD_JM1;
      ST_SO_CMP:  op = status.gt_v ? OP_WR_J : OP_WR_V;
      ST_FIN:     if (status.out_free) op = OP_EMIT;
      default:    op = OP_NONE;
    endcase
  end

  a_emit_only_fin: assert property (@(posedge clk) disable iff (rst)
    (op == OP_EMIT) |-> (state == ST_FIN))
    else $error("result emitted outside finish");

  a_load_from_idle: assert property (@(posedge clk) disable iff (rst)
    (op == OP_LOAD) |=> (state == ST_DISPATCH))
    else $error("load did not start dispatch");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ready)
    else $error("ready while busy");

endmodule

// File: rtl/core/sorted_code_table_unit.sv
// Sorted code table: holds up to TABLE_DEPTH distinct keys of CODE_BYTES
// bytes (first character in the top byte of s_tdata, lower bytes masked
// off) in one single-port-read memory, and serves one request at a time.
// s_tuser selects lookup, ordered add, tail add or sort; every request
// returns exactly one result on the m_ side. A new request is taken only
// while the controller is idle; a finished result waits in its own
// register so the next request can be taken while it is pending. Cost is
// set by the memory read latency, one key compare per read: lookup is a
// binary search and, on a miss, a scan of the missing entries; an
// ordered add is a search, a scan to the insert point, then one read and
// one write per shifted entry; a tail add scans every entry; and sort is
// an in-place insertion sort, O(n^2) element moves worst case. The table
// needs no clearing after reset; entries past the fill count are never
// read.
module sorted_code_table_unit #(
  parameter int TABLE_DEPTH = 256,
  parameter int CODE_BYTES  = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [63:0] code
  input  logic [1:0]  s_tuser,   // [1:0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] position, [8] found, [9] is_missing,
                                 // [10] table_full, [19:11] entries, [23:20] 0
  input  logic        cfg_we,
  input  logic        cfg_index, // 0 missing_count, 1 sort_enabled
  input  logic [1:0]  cfg_data
);
  import sct_pkg::*;

  op_t     op;
  status_t status;

  logic [7:0] position;
  logic       found, is_missing, table_full;
  logic [8:0] entries;

  sct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .op       (op)
  );

  sct_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .CODE_BYTES  (CODE_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .op           (op),
    .status       (status),
    .kind_in      (s_tuser),
    .code_in      (s_tdata),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_position (position),
    .out_found    (found),
    .out_missing  (is_missing),
    .out_full     (table_full),
    .out_entries  (entries)
  );

  // result packing, lowest field first
  assign m_tdata = {4'd0, entries, table_full, is_missing, found, position};

endmodule
